/* rtl/esc_enc_pkg.sv */
`timescale 1ns / 1ps

package esc_enc_pkg;

  localparam int CHAR_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_W     = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_RAW_TABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_TABLE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_COUNT = 2'd3;

  localparam logic [CFG_DATA_W-1:0] RAW_TABLE_RESET = 64'h0B09_0D0C_0A08_0700;
  localparam logic [CFG_DATA_W-1:0] MAP_TABLE_RESET = 64'h7674_726E_6261_3030;
  localparam logic [COUNT_W-1:0]    COUNT_RESET     = 4'd8;

  typedef enum logic [1:0] {
    K_PRINT = 2'd0,
    K_ESC   = 2'd1,
    K_HEX1  = 2'd2,
    K_HEX2  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  data;
    logic               string_end;
  } cmd_t;

endpackage

/* rtl/esc_enc_in_if.sv */
`timescale 1ns / 1ps

interface esc_enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

/* rtl/esc_enc_out_if.sv */
`timescale 1ns / 1ps

interface esc_enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       ends_string;

  modport source (output valid, output out_char, output run_last, output ends_string,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input ends_string,
                  output ready);
endinterface

/* rtl/escape_char_encoder.sv */
`timescale 1ns / 1ps
// The first character of an item passes through the command queue and then the output
// register on its way to the output.
// Throughput: one output character per cycle while the queue holds an item and the
// sink is ready; the back-end character sequencer sends 1 (printable), 2 (table
// escape), 4 or 5 (hex form) characters per item. Reset clears the command queue and
// the output register and restores the default tables and counts.
module escape_char_encoder
  import esc_enc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  esc_enc_in_if.sink             in_ch,
  esc_enc_out_if.source          out_ch
);

  cmd_t wr_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  esc_enc_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .queue_full(full),
    .push      (push),
    .cmd       (wr_cmd)
  );

  esc_enc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_cmd(wr_cmd),
    .full  (full),
    .pop   (pop),
    .rd_cmd(head),
    .empty (empty)
  );

  esc_enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(!empty),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/esc_enc_front.sv */
`timescale 1ns / 1ps

module esc_enc_front
  import esc_enc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  esc_enc_in_if.sink             in_ch,
  input  logic                   queue_full,
  output logic                   push,
  output cmd_t                   cmd
);

  localparam int TABLE_W = TABLE_ENTRIES * CHAR_W;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(TABLE_ENTRIES);
  localparam logic [TABLE_W-1:0] RAW_RESET = RAW_TABLE_RESET[TABLE_W-1:0];
  localparam logic [TABLE_W-1:0] MAP_RESET = MAP_TABLE_RESET[TABLE_W-1:0];

  logic [TABLE_W-1:0]       raw_table;
  logic [TABLE_W-1:0]       map_table;
  logic [COUNT_W-1:0]       raw_count;
  logic [COUNT_W-1:0]       map_count;
  logic [COUNT_W-1:0]       raw_lim;
  logic [COUNT_W-1:0]       map_lim;
  logic [TABLE_ENTRIES-1:0] hit;
  logic [IDX_W-1:0]         idx;
  logic                     printable;
  logic                     escaped;
  logic [CHAR_W-1:0]        letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_table <= RAW_RESET;
      map_table <= MAP_RESET;
      raw_count <= COUNT_RESET;
      map_count <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAW_TABLE: raw_table <= cfg_data[TABLE_W-1:0];
        REG_RAW_COUNT: raw_count <= cfg_data[COUNT_W-1:0];
        REG_MAP_TABLE: map_table <= cfg_data[TABLE_W-1:0];
        REG_MAP_COUNT: map_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign raw_lim = (raw_count > COUNT_MAX) ? COUNT_MAX : raw_count;
  assign map_lim = (map_count > COUNT_MAX) ? COUNT_MAX : map_count;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i] = (raw_table[i*CHAR_W +: CHAR_W] == in_ch.in_byte) && (COUNT_W'(i) < raw_lim);
    end
  end

  // The lowest matching entry wins.
  always_comb begin
    idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign letter    = map_table[idx*CHAR_W +: CHAR_W];
  assign escaped   = (|hit) && (COUNT_W'(idx) < map_lim);
  assign printable = (in_ch.in_byte >= 8'h20) && (in_ch.in_byte <= 8'h7E);

  always_comb begin
    cmd.string_end = in_ch.string_end;
    cmd.data       = in_ch.in_byte;
    if (printable) begin
      cmd.kind = K_PRINT;
    end else if (escaped) begin
      cmd.kind = K_ESC;
      cmd.data = letter;
    end else if (in_ch.in_byte[7:4] != 4'd0) begin
      cmd.kind = K_HEX2;
    end else begin
      cmd.kind = K_HEX1;
    end
  end

  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full;

endmodule

/* rtl/esc_enc_fifo.sv */
`timescale 1ns / 1ps

module esc_enc_fifo
  import esc_enc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full   = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/esc_enc_back.sv */
`timescale 1ns / 1ps

module esc_enc_back
  import esc_enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        head_valid,
  output logic        pop,
  esc_enc_out_if.source out_ch
);

  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X         = 8'h78;

  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + CHAR_W'(nib);
    end else begin
      c = 8'h61 + CHAR_W'(nib - 4'd10);
    end
    return c;
  endfunction

  logic [2:0]        seq;
  logic [2:0]        run_len;
  logic [CHAR_W-1:0] char_next;
  logic              is_last;
  logic              load;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              run_last;
  logic              ends_string;

  always_comb begin
    unique case (head.kind)
      K_PRINT: run_len = 3'd1;
      K_ESC:   run_len = 3'd2;
      K_HEX1:  run_len = 3'd4;
      K_HEX2:  run_len = 3'd5;
      default: run_len = 3'd1;
    endcase
  end

  always_comb begin
    char_next = head.data;
    unique case (head.kind) inside
      K_PRINT: char_next = head.data;
      K_ESC:   char_next = (seq == 3'd0) ? CH_BACKSLASH : head.data;
      K_HEX1, K_HEX2: begin
        case (seq)
          3'd0:    char_next = CH_BACKSLASH;
          3'd1:    char_next = CH_ZERO;
          3'd2:    char_next = CH_X;
          3'd3:    char_next = (head.kind == K_HEX2) ? hex_digit(head.data[7:4])
                                                     : hex_digit(head.data[3:0]);
          default: char_next = hex_digit(head.data[3:0]);
        endcase
      end
      default: char_next = head.data;
    endcase
  end

  assign is_last = (seq == run_len - 3'd1);
  assign load    = head_valid && (!out_valid || out_ch.ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seq       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        seq       <= is_last ? 3'd0 : seq + 3'd1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= char_next;
      run_last    <= is_last;
      ends_string <= is_last && head.string_end;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_char    = out_char;
  assign out_ch.run_last    = run_last;
  assign out_ch.ends_string = ends_string;

  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!ends_string || run_last))
    else $error("ends_string set on a character that does not close its run");

  a_seq_in_run: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (seq < run_len))
    else $error("character counter ran past the length of the run");

  a_run_holds_head: assert property (@(posedge clk) disable iff (rst)
    (load && !is_last) |=> head_valid)
    else $error("queue head left before its run was finished");

endmodule

/* test/escape_char_encoder_tb.sv */
`timescale 1ns / 1ps

module escape_char_encoder_tb;
  import esc_enc_pkg::*;

  localparam int TABLE_ENTRIES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PERCENT = 27;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_X = 8'h78;
  localparam logic [7:0] CHAR_A_LOWER = 8'h61;
  localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [7:0] LAST_PRINTABLE = 8'h7E;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       ends_string;
  } text_char_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  esc_enc_in_if  in_ch ();
  esc_enc_out_if out_ch ();

  escape_char_encoder #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  logic [63:0] raw_codes;
  logic [3:0]  raw_used;
  logic [63:0] map_letters;
  logic [3:0]  map_used;

  text_char_t expected_text[$];
  text_char_t next_char;
  bit         no_idle;
  int         error_count;
  int         cycle_count;
  int         bytes_sent;
  int         chars_checked;
  int         settings_applied;

  always #10 clk = ~clk;

  function automatic bit take_idle();
    return !no_idle && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? CHAR_ZERO + 8'(nib) : CHAR_A_LOWER + 8'(nib - 4'd10);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Expected text for one source byte under the current table settings.
  task automatic escape_byte(input logic [7:0] code, input logic last_of_string);
    logic [7:0] seq[5];
    int n;
    int raw_lim;
    int map_lim;
    bit found;
    bit escaped;
    text_char_t c;
    n = 0;
    found = 0;
    escaped = 0;
    if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE) begin
      seq[0] = code;
      n = 1;
    end else begin
      raw_lim = (raw_used > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(raw_used);
      map_lim = (map_used > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(map_used);
      if (raw_lim > 0 && map_lim > 0) begin
        for (int i = 0; i < raw_lim; i++) begin
          if (!found && raw_codes[8*i +: 8] == code) begin
            found = 1;
            if (i < map_lim) begin
              seq[0] = CHAR_BACKSLASH;
              seq[1] = map_letters[8*i +: 8];
              n = 2;
              escaped = 1;
            end
          end
        end
      end
      if (!escaped) begin
        seq[0] = CHAR_BACKSLASH;
        seq[1] = CHAR_ZERO;
        seq[2] = CHAR_X;
        n = 3;
        if (code >= 8'h10) begin
          seq[n] = hex_digit(code[7:4]);
          n++;
        end
        seq[n] = hex_digit(code[3:0]);
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      c.out_char = seq[k];
      c.run_last = (k == n - 1);
      c.ends_string = (k == n - 1) && last_of_string;
      expected_text.insert(expected_text.size(), c);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] code, input logic last_of_string);
    while (take_idle()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= code;
    in_ch.string_end <= last_of_string;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    escape_byte(code, last_of_string);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_config(input logic [63:0] rt, input logic [3:0] rc,
                              input logic [63:0] mt, input logic [3:0] mc);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_RAW_TABLE;
    cfg_data <= rt;
    @(negedge clk);
    cfg_index <= REG_RAW_COUNT;
    cfg_data <= {{(CFG_DATA_W-COUNT_W){1'b0}}, rc};
    @(negedge clk);
    cfg_index <= REG_MAP_TABLE;
    cfg_data <= mt;
    @(negedge clk);
    cfg_index <= REG_MAP_COUNT;
    cfg_data <= {{(CFG_DATA_W-COUNT_W){1'b0}}, mc};
    @(negedge clk);
    cfg_we <= 1'b0;
    raw_codes = rt;
    raw_used = rc;
    map_letters = mt;
    map_used = mc;
    settings_applied++;
  endtask

  task automatic test_default_tables();
    logic [7:0] codes[18] = '{8'h00, 8'h07, 8'h08, 8'h0A, 8'h0C, 8'h0D, 8'h09, 8'h0B,
                              8'h20, 8'h7E, 8'h41, 8'h01, 8'h0F, 8'h10, 8'h1F, 8'h7F,
                              8'h80, 8'hFF};
    foreach (codes[i]) send_byte(codes[i], (i % 5) == 4 || i == 17);
  endtask

  task automatic test_table_edges();
    // With no raw entries every control byte, the zero byte too, takes the hex form.
    apply_config(RAW_TABLE_RESET, 4'd0, MAP_TABLE_RESET, 4'd8);
    send_byte(8'h00, 1'b1);
    send_byte(8'h0A, 1'b0);
    apply_config(RAW_TABLE_RESET, 4'd8, MAP_TABLE_RESET, 4'd0);
    send_byte(8'h07, 1'b1);
    // Counts above the table size saturate; a first match past the map gives hex.
    apply_config(RAW_TABLE_RESET, 4'd15, MAP_TABLE_RESET, 4'd3);
    send_byte(8'h00, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h0A, 1'b1);
    apply_config(64'h0202_0101_0303_0101, 4'd8, 64'hFF00_7A79_7877_7675, 4'd15);
    send_byte(8'h01, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h02, 1'b1);
    apply_config({64{1'b1}}, 4'd8, 64'h0000_0000_0000_0000, 4'd1);
    send_byte(8'hFF, 1'b1);
    apply_config(64'h0000_0000_0000_0041, 4'd8, {64{1'b1}}, 4'd8);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  function automatic logic [63:0] random_codes();
    logic [63:0] t;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(9)) inside
        [0:3]:   t[8*i +: 8] = 8'($urandom_range(31));
        [4:6]:   t[8*i +: 8] = 8'($urandom_range(255, 127));
        default: t[8*i +: 8] = 8'($urandom);
      endcase
    end
    return t;
  endfunction

  function automatic logic [3:0] random_count();
    case ($urandom_range(9)) inside
      0:       return 4'd0;
      1:       return 4'($urandom_range(15, 9));
      [2:4]:   return 4'($urandom_range(7, 1));
      default: return 4'd8;
    endcase
  endfunction

  task automatic test_random_settings();
    logic [7:0] code;
    for (int phase = 0; phase < 5; phase++) begin
      apply_config(random_codes(), random_count(), 64'({$urandom, $urandom}), random_count());
      no_idle = (phase == 3);
      for (int n = 0; n < 80; n++) begin
        case ($urandom_range(9)) inside
          [0:3]:   code = raw_codes[8*$urandom_range(7) +: 8];
          [4:5]:   code = 8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE));
          default: code = 8'($urandom);
        endcase
        send_byte(code, $urandom_range(7) == 0);
        if (phase == 1 && n == 40) wait_idle();
      end
      no_idle = 0;
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready <= !rst && (no_idle || $urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h", out_ch.out_char));
      end else begin
        next_char = expected_text.pop_front();
        chars_checked++;
        if (out_ch.out_char !== next_char.out_char)
          report_mismatch($sformatf("out_char %h, expected %h", out_ch.out_char,
                                    next_char.out_char));
        if (out_ch.run_last !== next_char.run_last)
          report_mismatch($sformatf("run_last %b, expected %b on char %h",
                                    out_ch.run_last, next_char.run_last,
                                    next_char.out_char));
        if (out_ch.ends_string !== next_char.ends_string)
          report_mismatch($sformatf("ends_string %b, expected %b on char %h",
                                    out_ch.ends_string, next_char.ends_string,
                                    next_char.out_char));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d characters still expected.", expected_text.size());
      $display("escape_char_encoder_tb failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_RAW_TABLE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.string_end = 1'b0;
    out_ch.ready = 1'b0;
    no_idle = 0;
    error_count = 0;
    cycle_count = 0;
    bytes_sent = 0;
    chars_checked = 0;
    settings_applied = 0;
    raw_codes = RAW_TABLE_RESET;
    raw_used = COUNT_RESET;
    map_letters = MAP_TABLE_RESET;
    map_used = COUNT_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_tables();
    test_table_edges();
    test_random_settings();
    wait_idle();
    repeat (10) @(negedge clk);

    $display("Sent %0d bytes under %0d table settings after reset; checked %0d characters.",
             bytes_sent, settings_applied, chars_checked);
    if (error_count == 0) begin
      $display("escape_char_encoder_tb passed");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("escape_char_encoder_tb failed");
    end
    $finish;
  end

endmodule
